// File: src/pcxrld_pkg.sv
// Shared types and constants for the PCX run-length line decoder.
package pcxrld_pkg;

  // Encoded byte layout.
  localparam logic [1:0] RUN_MARK   = 2'b11;
  localparam int         COUNT_BITS = 6;

  // Configuration register indexes.
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_LINE_BYTES   = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic step;
    logic flush_move;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start_run;
    logic run_over;
    logic final_step;
    logic emits;
    logic hold_valid;
    logic out_free;
  } dp_status_t;

endpackage

// File: src/pcxrld_ctrl.sv
// Controller state machine for the PCX run-length line decoder.
module pcxrld_ctrl
  import pcxrld_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   step_blocked;

  // A step that emits must push the held pixel out, so it needs a free output slot.
  assign step_blocked = status.emits && status.hold_valid && !status.out_free;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && status.start_run) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (status.run_over) begin
          state_next = ST_FLUSH;
        end else if (!step_blocked && status.final_step) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!status.hold_valid || status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_stall       = 1'b1;
    cmd.accept     = 1'b0;
    cmd.step       = 1'b0;
    cmd.flush_move = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_RUN: begin
        cmd.step = !status.run_over && !step_blocked;
      end
      ST_FLUSH: begin
        cmd.flush_move = status.hold_valid && status.out_free;
      end
      default: in_stall = 1'b1;
    endcase
  end

endmodule

// File: src/pcxrld_datapath.sv
// Datapath for the PCX run-length line decoder: registers, positions and output stage.
module pcxrld_datapath
  import pcxrld_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  logic [7:0] encoded_byte,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] pixel_index,
  output logic       line_end,
  output logic       image_end,
  output logic       last_of_run
);

  // Configuration registers.
  logic [15:0] image_width;
  logic [15:0] line_bytes;
  logic [15:0] image_height;

  // Decoder state.
  logic                  awaiting_value;
  logic [COUNT_BITS-1:0] pending_count;
  logic [15:0]           column_position;
  logic [15:0]           line_position;
  logic                  image_done;
  logic [7:0]            run_value;
  logic [COUNT_BITS-1:0] remaining;

  // Held pixel, released once it is known whether it ends its run.
  logic       hold_valid;
  logic [7:0] hold_pixel;
  logic       hold_le;
  logic       hold_ie;

  // Step arithmetic.
  logic [15:0] lb_eff;
  logic [15:0] ih_eff;
  logic [15:0] kept;
  logic [16:0] col_inc;
  logic [16:0] line_inc;
  logic        emits;
  logic        step_le;
  logic        step_ie;
  logic        col_wrap;
  logic        line_wrap;
  logic        is_run_byte;
  logic        out_free;
  logic        push_out;

  assign lb_eff    = (line_bytes == 16'd0) ? 16'd1 : line_bytes;
  assign ih_eff    = (image_height == 16'd0) ? 16'd1 : image_height;
  assign kept      = (image_width < lb_eff) ? image_width : lb_eff;
  assign col_inc   = {1'b0, column_position} + 17'd1;
  assign line_inc  = {1'b0, line_position} + 17'd1;
  assign emits     = column_position < kept;
  assign step_le   = col_inc == {1'b0, kept};
  assign step_ie   = step_le && (line_inc >= {1'b0, ih_eff});
  assign col_wrap  = col_inc >= {1'b0, lb_eff};
  assign line_wrap = line_inc >= {1'b0, ih_eff};

  assign is_run_byte = encoded_byte[7:6] == RUN_MARK;
  assign out_free    = !out_valid || !out_stall;
  assign push_out    = cmd.step && emits && hold_valid;

  // Status toward the controller.
  assign status.start_run  = !image_done && (awaiting_value || !is_run_byte);
  assign status.run_over   = (remaining == '0) || image_done;
  assign status.final_step = (remaining == COUNT_BITS'(1)) || (col_wrap && line_wrap);
  assign status.emits      = emits;
  assign status.hold_valid = hold_valid;
  assign status.out_free   = out_free;

  // Configuration writes; an unused index is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 16'd1;
      line_bytes   <= 16'd1;
      image_height <= 16'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_LINE_BYTES:   line_bytes   <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Byte intake and run stepping.
  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_value  <= 1'b0;
      pending_count   <= '0;
      column_position <= '0;
      line_position   <= '0;
      image_done      <= 1'b0;
      remaining       <= '0;
      hold_valid      <= 1'b0;
    end else begin
      if (cmd.accept && !image_done) begin
        if (awaiting_value) begin
          awaiting_value <= 1'b0;
          pending_count  <= '0;
          run_value      <= encoded_byte;
          remaining      <= pending_count;
        end else if (is_run_byte) begin
          awaiting_value <= 1'b1;
          pending_count  <= encoded_byte[COUNT_BITS-1:0];
        end else begin
          run_value <= encoded_byte;
          remaining <= COUNT_BITS'(1);
        end
      end
      if (cmd.step) begin
        remaining <= remaining - COUNT_BITS'(1);
        if (emits) begin
          hold_valid <= 1'b1;
          hold_pixel <= run_value;
          hold_le    <= step_le;
          hold_ie    <= step_ie;
        end
        if (col_wrap) begin
          column_position <= '0;
          line_position   <= line_inc[15:0];
          if (line_wrap) begin
            image_done <= 1'b1;
          end
        end else begin
          column_position <= col_inc[15:0];
        end
      end
      if (cmd.flush_move) begin
        hold_valid <= 1'b0;
      end
    end
  end

  // Output register: valid control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_out || cmd.flush_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register: payload.
  always_ff @(posedge clk) begin
    if (push_out || cmd.flush_move) begin
      pixel_index <= hold_pixel;
      line_end    <= hold_le;
      image_end   <= hold_ie;
      last_of_run <= cmd.flush_move;
    end
  end

endmodule

// File: src/pcx_rle_line_decoder.sv
// Top level of the PCX run-length line decoder.
// Usage: encoded image body bytes enter on in_valid / in_stall / encoded_byte, one
// beat per byte. Decoded pixels leave on out_valid / out_stall with pixel_index,
// line_end, image_end and last_of_run. Width, padded line length and height are
// written on the cfg port (cfg_valid, cfg_ready, cfg_index, cfg_data) while idle;
// cfg_ready is always high.
// A run byte is taken in the idle state alone; a literal passes through the idle,
// run and flush states, and the value byte of a run through idle, one run step per
// column (none for a count of zero) and flush; the controller steps one decoded
// column per cycle through the position counters unless an emitting step waits.
// A byte's last pixel is released in the flush state once the output has room.
// When the receiver stalls, the output register holds its beat; a further emitting
// step waits, so input is held off until the pixels drain.
// Reset (rst, synchronous) sets width, line length and height to 1, clears the
// positions and the pending run, and empties the output stage.
module pcx_rle_line_decoder
  import pcxrld_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  encoded_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  pixel_index,
  output logic        line_end,
  output logic        image_end,
  output logic        last_of_run
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  // Sequencer.
  pcxrld_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Registers, counters and output stage.
  pcxrld_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .encoded_byte (encoded_byte),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_index  (pixel_index),
    .line_end     (line_end),
    .image_end    (image_end),
    .last_of_run  (last_of_run)
  );

`ifndef NO_ASSERTIONS
  // No pixel may be left in the hold slot while new bytes are taken.
  a_idle_hold_empty: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !status.hold_valid)
    else $error("held pixel left over while accepting input");

  // The output register is only reloaded when its beat is gone or leaving.
  a_flush_room: assert property (@(posedge clk) disable iff (rst)
    cmd.flush_move |-> status.out_free)
    else $error("flush overwrote a stalled output beat");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && status.emits && status.hold_valid) |-> status.out_free)
    else $error("step overwrote a stalled output beat");

  // No column is stepped once the run is over.
  a_step_in_run: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !status.run_over)
    else $error("step issued after the run ended");
`endif

endmodule
